>>> rtl/core/lst_pkg.sv
// Package for the latency statistics table: widths, constants, entry layout,
// status and state codes, and the control struct shared by the core modules.
// Depends on nothing.
package lst_pkg;

  localparam int NUM_CATEGORIES = 16;
  localparam int IDX_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

  localparam int CAT_W  = 5;
  localparam int SEC_W  = 32;
  localparam int USEC_W = 20;
  localparam int TOT_W  = 48;
  localparam int CNT_W  = 32;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;
  localparam logic [15:0]       MIN_RESET    = 16'hBEAF;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TOT_W-1:0]  tot_sec;
    logic [USEC_W-1:0] tot_usec;
    logic [SEC_W-1:0]  min_sec;
    logic [USEC_W-1:0] min_usec;
    logic [SEC_W-1:0]  max_sec;
    logic [USEC_W-1:0] max_usec;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    count:    '0,
    tot_sec:  '0,
    tot_usec: '0,
    min_sec:  SEC_W'(MIN_RESET),
    min_usec: USEC_W'(MIN_RESET),
    max_sec:  '0,
    max_usec: '0
  };

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_CAT = 2'd1,
    ST_LATE    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIFF,
    S_ACC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic diff;
    logic upd;
  } ctrl_t;

  function automatic logic [USEC_W-1:0] clamp_usec(input logic [USEC_W-1:0] v);
    return (v > USEC_MAX) ? USEC_MAX : v;
  endfunction

endpackage

>>> rtl/core/lst_entry_mem.sv
// Per-category entry memory with a registered read and per-entry
// valid bits; an entry never written reads as the reset entry. Uses lst_pkg.
module lst_entry_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [lst_pkg::IDX_W-1:0]    rd_idx_i,
  input  logic                         wr_en_i,
  input  logic [lst_pkg::IDX_W-1:0]    wr_idx_i,
  input  lst_pkg::entry_t              wr_entry_i,
  output lst_pkg::entry_t              rd_entry_o
);

  lst_pkg::entry_t                         mem [lst_pkg::NUM_CATEGORIES];
  logic [lst_pkg::NUM_CATEGORIES-1:0]      vld_q;
  lst_pkg::entry_t                         rd_data_q;
  logic                                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_entry_o = rd_vld_q ? rd_data_q : lst_pkg::ENTRY_RESET;

endmodule

>>> rtl/core/lst_update.sv
// Datapath: captures the event, forms the duration, then builds the updated
// entry and the result registers. Uses lst_pkg.
module lst_update (
  input  logic                          clk_i,
  input  lst_pkg::ctrl_t                ctrl_i,
  input  logic [lst_pkg::CAT_W-1:0]     category_i,
  input  logic [lst_pkg::SEC_W-1:0]     start_sec_i,
  input  logic [lst_pkg::USEC_W-1:0]    start_usec_i,
  input  logic [lst_pkg::SEC_W-1:0]     end_sec_i,
  input  logic [lst_pkg::USEC_W-1:0]    end_usec_i,
  input  lst_pkg::entry_t               entry_i,
  output logic                          wr_en_o,
  output logic [lst_pkg::IDX_W-1:0]     wr_idx_o,
  output lst_pkg::entry_t               wr_entry_o,
  output lst_pkg::status_e              status_o,
  output logic [lst_pkg::CAT_W-1:0]     category_echo_o,
  output logic [lst_pkg::SEC_W-1:0]     duration_sec_o,
  output logic [lst_pkg::USEC_W-1:0]    duration_usec_o,
  output lst_pkg::entry_t               entry_o
);

  logic [lst_pkg::CAT_W-1:0]  cat_q;
  logic                       bad_q;
  logic [lst_pkg::SEC_W-1:0]  ss_q, es_q;
  logic [lst_pkg::USEC_W-1:0] su_q, eu_q;

  logic                       late_q;
  logic [lst_pkg::SEC_W-1:0]  ds_q;
  logic [lst_pkg::USEC_W-1:0] du_q;

  lst_pkg::status_e           status_q;
  logic [lst_pkg::CAT_W-1:0]  echo_q;
  logic [lst_pkg::SEC_W-1:0]  res_ds_q;
  logic [lst_pkg::USEC_W-1:0] res_du_q;
  lst_pkg::entry_t            res_entry_q;

  logic                       late_d, borrow;
  logic [lst_pkg::SEC_W-1:0]  ds_d;
  logic [lst_pkg::USEC_W:0]   du_w;
  logic [lst_pkg::USEC_W:0]   tu_w;
  logic                       carry;
  logic [lst_pkg::TOT_W:0]    ts_w;
  lst_pkg::entry_t            upd_entry;

  always_comb begin
    late_d = {es_q, eu_q} < {ss_q, su_q};
    borrow = eu_q < su_q;
    ds_d   = es_q - ss_q - lst_pkg::SEC_W'(borrow);
    du_w   = {1'b0, eu_q} + (borrow ? {1'b0, lst_pkg::USEC_PER_SEC} : '0) - {1'b0, su_q};
  end

  always_comb begin
    tu_w  = {1'b0, entry_i.tot_usec} + {1'b0, du_q};
    carry = tu_w >= {1'b0, lst_pkg::USEC_PER_SEC};
    if (carry) begin
      tu_w = tu_w - {1'b0, lst_pkg::USEC_PER_SEC};
    end
    ts_w = {1'b0, entry_i.tot_sec} + (lst_pkg::TOT_W + 1)'(ds_q)
         + (lst_pkg::TOT_W + 1)'(carry);

    upd_entry = entry_i;
    if (ts_w[lst_pkg::TOT_W]) begin
      upd_entry.tot_sec  = '1;
      upd_entry.tot_usec = lst_pkg::USEC_MAX;
    end else begin
      upd_entry.tot_sec  = ts_w[lst_pkg::TOT_W-1:0];
      upd_entry.tot_usec = tu_w[lst_pkg::USEC_W-1:0];
    end
    if (entry_i.count != '1) begin
      upd_entry.count = entry_i.count + 1'b1;
    end
    if ({ds_q, du_q} < {entry_i.min_sec, entry_i.min_usec}) begin
      upd_entry.min_sec  = ds_q;
      upd_entry.min_usec = du_q;
    end
    if ({ds_q, du_q} > {entry_i.max_sec, entry_i.max_usec}) begin
      upd_entry.max_sec  = ds_q;
      upd_entry.max_usec = du_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cat_q <= category_i;
      bad_q <= 32'(category_i) >= lst_pkg::NUM_CATEGORIES;
      ss_q  <= start_sec_i;
      es_q  <= end_sec_i;
      su_q  <= lst_pkg::clamp_usec(start_usec_i);
      eu_q  <= lst_pkg::clamp_usec(end_usec_i);
    end
    if (ctrl_i.diff) begin
      late_q <= late_d;
      ds_q   <= ds_d;
      du_q   <= du_w[lst_pkg::USEC_W-1:0];
    end
    if (ctrl_i.upd) begin
      echo_q <= cat_q;
      if (bad_q) begin
        status_q    <= lst_pkg::ST_BAD_CAT;
        res_ds_q    <= '0;
        res_du_q    <= '0;
        res_entry_q <= '0;
      end else if (late_q) begin
        status_q    <= lst_pkg::ST_LATE;
        res_ds_q    <= '0;
        res_du_q    <= '0;
        res_entry_q <= entry_i;
      end else begin
        status_q    <= lst_pkg::ST_OK;
        res_ds_q    <= ds_q;
        res_du_q    <= du_q;
        res_entry_q <= upd_entry;
      end
    end
  end

  assign wr_en_o         = ctrl_i.upd && !bad_q && !late_q;
  assign wr_idx_o        = cat_q[lst_pkg::IDX_W-1:0];
  assign wr_entry_o      = upd_entry;
  assign status_o        = status_q;
  assign category_echo_o = echo_q;
  assign duration_sec_o  = res_ds_q;
  assign duration_usec_o = res_du_q;
  assign entry_o         = res_entry_q;

endmodule

>>> rtl/core/latency_stats_table.sv
// Result strobe done_o is high in S_OUT, reached from the transfer via S_DIFF, S_ACC.
// busy covers the duration and read-modify-write cycles of the entry memory,
// and a new start is taken while done_o shows.
// Reset: asynchronous, clears all control state and marks every table entry as reset
// (count, totals and maximum zero, minimum 0xBEAF.0xBEAF); no clearing pass is needed.
module latency_stats_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  output logic                          done_o,
  input  logic [lst_pkg::CAT_W-1:0]     category_i,
  input  logic [lst_pkg::SEC_W-1:0]     start_sec_i,
  input  logic [lst_pkg::USEC_W-1:0]    start_usec_i,
  input  logic [lst_pkg::SEC_W-1:0]     end_sec_i,
  input  logic [lst_pkg::USEC_W-1:0]    end_usec_i,
  output logic [1:0]                    status_o,
  output logic [lst_pkg::CAT_W-1:0]     category_echo_o,
  output logic [lst_pkg::SEC_W-1:0]     duration_sec_o,
  output logic [lst_pkg::USEC_W-1:0]    duration_usec_o,
  output logic [lst_pkg::CNT_W-1:0]     event_count_o,
  output logic [lst_pkg::TOT_W-1:0]     total_sec_o,
  output logic [lst_pkg::USEC_W-1:0]    total_usec_o,
  output logic [lst_pkg::SEC_W-1:0]     min_sec_o,
  output logic [lst_pkg::USEC_W-1:0]    min_usec_o,
  output logic [lst_pkg::SEC_W-1:0]     max_sec_o,
  output logic [lst_pkg::USEC_W-1:0]    max_usec_o
);

  lst_pkg::state_e              state_q, state_d;
  lst_pkg::ctrl_t               ctrl;
  lst_pkg::entry_t              rd_entry, wr_entry, res_entry;
  lst_pkg::status_e             status;
  logic                         wr_en;
  logic [lst_pkg::IDX_W-1:0]    wr_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    unique case (state_q)
      lst_pkg::S_IDLE: state_d = start ? lst_pkg::S_DIFF : lst_pkg::S_IDLE;
      lst_pkg::S_DIFF: state_d = lst_pkg::S_ACC;
      lst_pkg::S_ACC:  state_d = lst_pkg::S_OUT;
      lst_pkg::S_OUT:  state_d = start ? lst_pkg::S_DIFF : lst_pkg::S_IDLE;
      default:         state_d = lst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_q == lst_pkg::S_DIFF) || (state_q == lst_pkg::S_ACC);
    done_o    = state_q == lst_pkg::S_OUT;
    ctrl.load = start && !busy;
    ctrl.diff = state_q == lst_pkg::S_DIFF;
    ctrl.upd  = state_q == lst_pkg::S_ACC;
  end

  lst_entry_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (ctrl.load),
    .rd_idx_i   (category_i[lst_pkg::IDX_W-1:0]),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry),
    .rd_entry_o (rd_entry)
  );

  lst_update u_upd (
    .clk_i           (clk_i),
    .ctrl_i          (ctrl),
    .category_i      (category_i),
    .start_sec_i     (start_sec_i),
    .start_usec_i    (start_usec_i),
    .end_sec_i       (end_sec_i),
    .end_usec_i      (end_usec_i),
    .entry_i         (rd_entry),
    .wr_en_o         (wr_en),
    .wr_idx_o        (wr_idx),
    .wr_entry_o      (wr_entry),
    .status_o        (status),
    .category_echo_o (category_echo_o),
    .duration_sec_o  (duration_sec_o),
    .duration_usec_o (duration_usec_o),
    .entry_o         (res_entry)
  );

  assign status_o      = status;
  assign event_count_o = res_entry.count;
  assign total_sec_o   = res_entry.tot_sec;
  assign total_usec_o  = res_entry.tot_usec;
  assign min_sec_o     = res_entry.min_sec;
  assign min_usec_o    = res_entry.min_usec;
  assign max_sec_o     = res_entry.max_sec;
  assign max_usec_o    = res_entry.max_usec;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result strobe missing three cycles after transfer");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && !$past(done_o))
    else $error("result strobe overlaps busy work");

  a_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == lst_pkg::S_ACC)
    else $error("entry write outside update cycle");

  a_bad_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == lst_pkg::ST_BAD_CAT) |-> (event_count_o == '0 && total_sec_o == '0))
    else $error("out-of-range result carries entry data");
`endif

endmodule
